### rtl/core/kbsm_pkg.sv
// Shared types and constants of the key bounce statistics monitor.
package kbsm_pkg;

  typedef enum logic [2:0] {
    REQ_SCAN   = 3'd0,
    REQ_SWEEP  = 3'd1,
    REQ_READ   = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_CANCEL = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_EX,
    ST_OUT
  } state_e;

  localparam logic [15:0] SAT16     = 16'hFFFF;
  localparam logic [7:0]  SAT8      = 8'd255;
  localparam logic [15:0] MIN_EDGES = 16'd3;
  localparam logic [25:0] WINDOW_RST   = 26'd40000;
  localparam logic [17:0] DEBOUNCE_RST = 18'd5000;

  typedef struct packed {
    logic        open;
    logic [31:0] start;
    logic [31:0] last;
    logic [15:0] edges;
    logic [15:0] press;
    logic [15:0] over;
    logic [15:0] burst;
    logic [7:0]  last_e;
    logic [7:0]  max_e;
    logic [15:0] dlast;
    logic [15:0] dmax;
    logic [15:0] dmin;
    logic [31:0] dsum;
  } rec_t;

endpackage

### rtl/core/kbsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kbsm_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                  wdata_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                  rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/core/kbsm_lane.sv
// One column lane: update of a key's record for the current request.
module kbsm_lane import kbsm_pkg::*; (
  input  req_e        req_i,
  input  logic        chg_i,
  input  logic        press_i,
  input  logic [31:0] now_i,
  input  logic [25:0] window_i,
  input  logic [17:0] debounce_i,
  input  rec_t        rec_i,
  output rec_t        rec_o
);
  logic [31:0] elapsed;
  logic        late;
  logic [31:0] dur;
  logic [15:0] d16;
  logic [7:0]  e8;
  rec_t        closed;

  assign elapsed = now_i - rec_i.start;
  assign late    = elapsed > {6'd0, window_i};
  assign dur     = rec_i.last - rec_i.start;
  assign d16     = (dur > {16'd0, SAT16}) ? SAT16 : dur[15:0];
  assign e8      = (rec_i.edges > {8'd0, SAT8}) ? SAT8 : rec_i.edges[7:0];

  always_comb begin
    closed = rec_i;
    if (rec_i.open) begin
      closed.last_e = e8;
      if (e8 > rec_i.max_e) begin
        closed.max_e = e8;
      end
      if (rec_i.edges >= MIN_EDGES) begin
        if (rec_i.burst != SAT16) begin
          closed.burst = rec_i.burst + 16'd1;
        end
        closed.dlast = d16;
        closed.dsum  = rec_i.dsum + {16'd0, d16};
        if (d16 > rec_i.dmax) begin
          closed.dmax = d16;
        end
        if (rec_i.dmin == 16'd0 || d16 < rec_i.dmin) begin
          closed.dmin = d16;
        end
        if (dur >= {14'd0, debounce_i} && rec_i.over != SAT16) begin
          closed.over = rec_i.over + 16'd1;
        end
      end
      closed.open  = 1'b0;
      closed.edges = 16'd0;
    end
  end

  always_comb begin
    rec_o = rec_i;
    case (req_i)
      REQ_SCAN: begin
        if (chg_i) begin
          if (rec_i.open && !late) begin
            if (rec_i.edges != SAT16) begin
              rec_o.edges = rec_i.edges + 16'd1;
            end
            rec_o.last = now_i;
          end else begin
            rec_o = closed;
            if (press_i) begin
              rec_o.open  = 1'b1;
              rec_o.start = now_i;
              rec_o.last  = now_i;
              rec_o.edges = 16'd1;
              if (rec_i.press != SAT16) begin
                rec_o.press = rec_i.press + 16'd1;
              end
            end
          end
        end
      end
      REQ_SWEEP: begin
        if (rec_i.open && late) begin
          rec_o = closed;
        end
      end
      REQ_CLEAR: begin
        rec_o = '0;
      end
      REQ_CANCEL: begin
        rec_o.open = 1'b0;
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end
endmodule

### rtl/core/key_bounce_statistics_monitor.sv
// Top level: sequencer, column lanes with their record RAMs, read merge.
//
//  channel  | dir | handshake               | word
//  s_axis   | in  | tvalid/tready           | request, 88 bits
//  m_axis   | out | tvalid/tready           | key statistics, 152 bits
//  cfg      | in  | cfg_we_i                | window length / debounce time
//
// A row scan reads and writes back one RAM row; sweep, clear and cancel
// do one read/write pair per row over all rows, all COLS lanes at once.
// A read first splits the key into row and column; an out-of-matrix read
// skips to output. After reset a clearing pass runs with s_axis_tready_o
// low. A pending result holds the sequencer until m_axis takes it.
module key_bounce_statistics_monitor import kbsm_pkg::*; #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // req_type[2:0] row_index[5:3] curr_row[21:6] prev_row[37:22]
  // now_us[69:38] key_num[85:70], zero fill
  input  logic [87:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // key_valid[0] actuations[16:1] over_cnt[32:17] chatter_cnt[48:33]
  // edges_last[56:49] edges_peak[64:57] dur_last[80:65] dur_total[112:81]
  // dur_peak[128:113] dur_low[144:129], zero fill
  output logic [151:0] m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [25:0]  cfg_data_i
);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int NKEYS = ROWS * COLS;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  state_e      st_q, st_d;
  req_e        req_q, req_d;
  logic [RW-1:0] row_q, row_d;
  logic [15:0] rem_q, rem_d;
  logic        kv_q, kv_d;
  logic [31:0] now_q, now_d;
  logic [15:0] curr_q, curr_d, prev_q, prev_d;
  logic        mvalid_q, mvalid_d;
  logic [151:0] mdata_q, mdata_d;
  logic [25:0] window_q;
  logic [17:0] debounce_q;
  logic [15:0] delta;
  logic        we;
  rec_t        lane_rd [COLS];
  rec_t        lane_wr [COLS];
  rec_t        sel;

  assign delta = curr_q ^ prev_q;
  assign we    = (st_q == ST_EX) && (req_q != REQ_READ);

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic chg, prs;
    if (c < 16) begin : g_in
      assign chg = delta[c];
      assign prs = curr_q[c];
    end else begin : g_none
      assign chg = 1'b0;
      assign prs = 1'b0;
    end
    kbsm_ram #(.W($bits(rec_t)), .D(ROWS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (row_q),
      .wdata_i (lane_wr[c]),
      .raddr_i (row_q),
      .rdata_o (lane_rd[c])
    );
    kbsm_lane u_lane (
      .req_i      (req_q),
      .chg_i      (chg),
      .press_i    (prs),
      .now_i      (now_q),
      .window_i   (window_q),
      .debounce_i (debounce_q),
      .rec_i      (lane_rd[c]),
      .rec_o      (lane_wr[c])
    );
  end

  assign sel = lane_rd[rem_q[CW-1:0]];

  always_comb begin
    st_d     = st_q;
    req_d    = req_q;
    row_d    = row_q;
    rem_d    = rem_q;
    kv_d     = kv_q;
    now_d    = now_q;
    curr_d   = curr_q;
    prev_d   = prev_q;
    mvalid_d = mvalid_q & ~m_axis_tready_i;
    mdata_d  = mdata_q;
    s_axis_tready_o = (st_q == ST_IDLE);
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d  = req_e'(s_axis_tdata_i[2:0]);
          curr_d = s_axis_tdata_i[21:6];
          prev_d = s_axis_tdata_i[37:22];
          now_d  = s_axis_tdata_i[69:38];
          rem_d  = s_axis_tdata_i[85:70];
          row_d  = '0;
          kv_d   = 1'b1;
          case (req_e'(s_axis_tdata_i[2:0]))
            REQ_SCAN: begin
              if (32'(s_axis_tdata_i[5:3]) < ROWS) begin
                row_d = RW'(s_axis_tdata_i[5:3]);
                st_d  = ST_RD;
              end
            end
            REQ_SWEEP, REQ_CLEAR, REQ_CANCEL: st_d = ST_RD;
            REQ_READ: begin
              if (32'(s_axis_tdata_i[85:70]) < NKEYS) begin
                st_d = ST_DIV;
              end else begin
                kv_d = 1'b0;
                st_d = ST_OUT;
              end
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        // row = highest r with key >= r*COLS, column = remainder
        for (int r = 1; r < ROWS; r++) begin
          if (32'(rem_q) >= r * COLS) begin
            row_d = RW'(r);
            rem_d = rem_q - 16'(r * COLS);
          end
        end
        st_d = ST_RD;
      end
      ST_RD: st_d = ST_EX;
      ST_EX: begin
        if (req_q == REQ_READ) begin
          st_d = ST_OUT;
        end else if (req_q == REQ_SCAN || row_q == ROW_LAST) begin
          st_d = ST_IDLE;
        end else begin
          row_d = row_q + RW'(1);
          st_d  = ST_RD;
        end
      end
      ST_OUT: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          st_d     = ST_IDLE;
          if (kv_q) begin
            mdata_d = {7'd0, sel.dmin, sel.dmax, sel.dsum, sel.dlast, sel.max_e,
                       sel.last_e, sel.burst, sel.over, sel.press, 1'b1};
          end else begin
            mdata_d = '0;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RD;
      req_q      <= REQ_CLEAR;
      row_q      <= '0;
      kv_q       <= 1'b0;
      mvalid_q   <= 1'b0;
      window_q   <= WINDOW_RST;
      debounce_q <= DEBOUNCE_RST;
    end else begin
      st_q     <= st_d;
      req_q    <= req_d;
      row_q    <= row_d;
      kv_q     <= kv_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) begin
        if (!cfg_idx_i) begin
          window_q <= cfg_data_i;
        end else begin
          debounce_q <= cfg_data_i[17:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    now_q   <= now_d;
    curr_q  <= curr_d;
    prev_q  <= prev_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
endmodule
